// ===== design/eyepix_pkg.sv =====
// ----------------------------------------------------------------------------
// eyepix_pkg
// shared constants for the eye pixel renderer: default sizes, item codes,
// configuration register indexes and fixed field widths
// ----------------------------------------------------------------------------
`default_nettype none

package eyepix_pkg;

  // default geometry
  localparam int SCREEN_SIZE_DEF   = 128;
  localparam int SCLERA_SIZE_DEF   = 256;
  localparam int IRIS_SIZE_DEF     = 128;
  localparam int IRIS_MAP_COLS_DEF = 512;
  localparam int IRIS_MAP_ROWS_DEF = 64;

  // item codes
  localparam logic [2:0] FUNC_RENDER = 3'd0;
  localparam logic [2:0] FUNC_SCLERA = 3'd1;
  localparam logic [2:0] FUNC_UPPER  = 3'd2;
  localparam logic [2:0] FUNC_LOWER  = 3'd3;
  localparam logic [2:0] FUNC_POLAR  = 3'd4;
  localparam logic [2:0] FUNC_IRIS   = 3'd5;

  // configuration register indexes
  localparam int CFG_IW = 3;
  localparam int CFG_DW = 12;
  localparam logic [CFG_IW-1:0] REG_IRIS_SCALE  = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SCLERA_OX   = 3'd1;
  localparam logic [CFG_IW-1:0] REG_SCLERA_OY   = 3'd2;
  localparam logic [CFG_IW-1:0] REG_UPPER_THR   = 3'd3;
  localparam logic [CFG_IW-1:0] REG_LOWER_THR   = 3'd4;
  localparam logic [CFG_IW-1:0] REG_EYE_SELECT  = 3'd5;
  localparam logic [CFG_IW-1:0] REG_OFFSET_X    = 3'd6;
  localparam logic [CFG_IW-1:0] REG_OFFSET_Y    = 3'd7;

  localparam logic [11:0] IRIS_SCALE_RST = 12'd128;

  // polar map entry layout: distance in the low bits, angle above
  localparam int DIST_W      = 7;
  localparam int ANGLE_W     = 9;
  localparam int SCALE_SHIFT = 7;
  localparam int ANGLE_SHIFT = 9;

  // reciprocal division of small sums by a constant
  localparam int RECIP_SHIFT = 20;

endpackage

`default_nettype wire

// ===== design/eye_pixel_renderer_top.sv =====
// ----------------------------------------------------------------------------
// eye_pixel_renderer_top
// renders one pixel of an animated eye per render transaction and loads the
// five image memories with write transactions
// ----------------------------------------------------------------------------
// A transaction is taken at every clock edge with start high; busy is always
// low. A render transaction inside the screen gives one result: out_valid is
// high for exactly one cycle with the display position and color, and the
// receiver cannot stall it. Write transactions and unused codes give no result.
// One item enters every cycle: each image memory has one write port and one
// read port and serves one item per cycle at a fixed stage, so writes and later
// reads stay in order. The image memories hold nothing useful after reset and
// must be loaded before they are rendered from. The user must write
// configuration only with no transaction in flight; the block does not check.
`default_nettype none

module eye_pixel_renderer_top
  import eyepix_pkg::*;
#(
  parameter int SCREEN_SIZE   = SCREEN_SIZE_DEF,
  parameter int SCLERA_SIZE   = SCLERA_SIZE_DEF,
  parameter int IRIS_SIZE     = IRIS_SIZE_DEF,
  parameter int IRIS_MAP_COLS = IRIS_MAP_COLS_DEF,
  parameter int IRIS_MAP_ROWS = IRIS_MAP_ROWS_DEF
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                start,
  output logic               busy,
  input  wire  [2:0]         in_func,
  input  wire  [15:0]        in_address,
  input  wire  [15:0]        in_data,
  input  wire  [6:0]         in_screen_x,
  input  wire  [6:0]         in_screen_y,
  output logic               out_valid,
  output logic [10:0]        out_pixel_x,
  output logic [10:0]        out_pixel_y,
  output logic [15:0]        out_color,
  input  wire                cfg_valid,
  output logic               cfg_ready,
  input  wire  [CFG_IW-1:0]  cfg_index,
  input  wire  [CFG_DW-1:0]  cfg_data
);

  localparam int SCL_DEPTH  = SCLERA_SIZE * SCLERA_SIZE;
  localparam int LID_DEPTH  = SCREEN_SIZE * SCREEN_SIZE;
  localparam int POL_DEPTH  = IRIS_SIZE * IRIS_SIZE;
  localparam int IRIS_DEPTH = IRIS_MAP_ROWS * IRIS_MAP_COLS;
  localparam int SCL_AW     = $clog2(SCL_DEPTH);
  localparam int LID_AW     = $clog2(LID_DEPTH);
  localparam int POL_AW     = $clog2(POL_DEPTH);
  localparam int IRIS_AW    = $clog2(IRIS_DEPTH);
  localparam int ROW_AW     = $clog2(IRIS_MAP_ROWS);
  localparam int COL_AW     = $clog2(IRIS_MAP_COLS);
  localparam int SCL_RECIP  = ((1 << RECIP_SHIFT) + SCLERA_SIZE - 1) / SCLERA_SIZE;
  localparam int BORDER     = (SCLERA_SIZE - IRIS_SIZE) / 2;

  localparam logic signed [10:0] BORDER_S  = 11'(BORDER);
  localparam logic signed [10:0] IRIS_LIM  = 11'(IRIS_SIZE);
  localparam logic [11:0]        ROW_LIM   = 12'(IRIS_MAP_ROWS);

  // configuration registers
  logic [11:0] iris_scale_r;
  logic [7:0]  sclera_ox_r;
  logic [7:0]  sclera_oy_r;
  logic [7:0]  upper_thr_r;
  logic [7:0]  lower_thr_r;
  logic        eye_sel_r;
  logic [9:0]  offset_x_r;
  logic [9:0]  offset_y_r;

  assign cfg_ready = 1'b1;
  assign busy      = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iris_scale_r <= IRIS_SCALE_RST;
      sclera_ox_r  <= '0;
      sclera_oy_r  <= '0;
      upper_thr_r  <= '0;
      lower_thr_r  <= '0;
      eye_sel_r    <= 1'b0;
      offset_x_r   <= '0;
      offset_y_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IRIS_SCALE: iris_scale_r <= cfg_data;
        REG_SCLERA_OX:  sclera_ox_r  <= cfg_data[7:0];
        REG_SCLERA_OY:  sclera_oy_r  <= cfg_data[7:0];
        REG_UPPER_THR:  upper_thr_r  <= cfg_data[7:0];
        REG_LOWER_THR:  lower_thr_r  <= cfg_data[7:0];
        REG_EYE_SELECT: eye_sel_r    <= cfg_data[0];
        REG_OFFSET_X:   offset_x_r   <= cfg_data[9:0];
        REG_OFFSET_Y:   offset_y_r   <= cfg_data[9:0];
        default: ;
      endcase
    end
  end

  // ---------------- stage 1: input register
  logic        s1_vld_r;
  logic [2:0]  s1_func_r;
  logic [15:0] s1_addr_r;
  logic [15:0] s1_data_r;
  logic [6:0]  s1_sx_r;
  logic [6:0]  s1_sy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s1_vld_r <= 1'b0;
    else        s1_vld_r <= start && !busy;
  end

  always_ff @(posedge clk) begin
    s1_func_r <= in_func;
    s1_addr_r <= in_address;
    s1_data_r <= in_data;
    s1_sx_r   <= in_screen_x;
    s1_sy_r   <= in_screen_y;
  end

  // ---------------- stage A: wrap, mirror, iris square test
  logic               rnd_nxt;
  logic               wen_nxt;
  logic [8:0]         sum_x;
  logic [8:0]         sum_y;
  logic [8:0]         q_x;
  logic [8:0]         q_y;
  logic [7:0]         cx_nxt;
  logic [7:0]         cy_nxt;
  logic [7:0]         lx_nxt;
  logic signed [10:0] ix_s;
  logic signed [10:0] iy_s;
  logic               iris_nxt;

  always_comb begin
    rnd_nxt = s1_vld_r && (s1_func_r == FUNC_RENDER)
              && (32'(s1_sx_r) < SCREEN_SIZE) && (32'(s1_sy_r) < SCREEN_SIZE);
    wen_nxt = s1_vld_r && (s1_func_r != FUNC_RENDER);
    sum_x   = 9'(sclera_ox_r) + 9'(s1_sx_r);
    sum_y   = 9'(sclera_oy_r) + 9'(s1_sy_r);
    q_x     = 9'((32'(sum_x) * SCL_RECIP) >> RECIP_SHIFT);
    q_y     = 9'((32'(sum_y) * SCL_RECIP) >> RECIP_SHIFT);
    cx_nxt  = 8'(sum_x - 9'(32'(q_x) * SCLERA_SIZE));
    cy_nxt  = 8'(sum_y - 9'(32'(q_y) * SCLERA_SIZE));
    lx_nxt  = eye_sel_r ? 8'(32'(SCREEN_SIZE - 1) - 32'(s1_sx_r)) : 8'(s1_sx_r);
    ix_s    = $signed({3'b000, sclera_ox_r}) + $signed({4'b0000, s1_sx_r}) - BORDER_S;
    iy_s    = $signed({3'b000, sclera_oy_r}) + $signed({4'b0000, s1_sy_r}) - BORDER_S;
    iris_nxt = (ix_s >= 0) && (iy_s >= 0) && (ix_s < IRIS_LIM) && (iy_s < IRIS_LIM);
  end

  logic        s2_rnd_r;
  logic        s2_wen_r;
  logic [2:0]  s2_func_r;
  logic [15:0] s2_addr_r;
  logic [15:0] s2_data_r;
  logic [7:0]  s2_cx_r;
  logic [7:0]  s2_cy_r;
  logic [7:0]  s2_lx_r;
  logic [6:0]  s2_sy_r;
  logic [7:0]  s2_ix_r;
  logic [7:0]  s2_iy_r;
  logic        s2_iris_r;
  logic [10:0] s2_px_r;
  logic [10:0] s2_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_rnd_r <= 1'b0;
      s2_wen_r <= 1'b0;
    end else begin
      s2_rnd_r <= rnd_nxt;
      s2_wen_r <= wen_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s2_func_r <= s1_func_r;
    s2_addr_r <= s1_addr_r;
    s2_data_r <= s1_data_r;
    s2_cx_r   <= cx_nxt;
    s2_cy_r   <= cy_nxt;
    s2_lx_r   <= lx_nxt;
    s2_sy_r   <= s1_sy_r;
    s2_ix_r   <= ix_s[7:0];
    s2_iy_r   <= iy_s[7:0];
    s2_iris_r <= iris_nxt;
    s2_px_r   <= 11'(s1_sx_r) + 11'(offset_x_r);
    s2_py_r   <= 11'(s1_sy_r) + 11'(offset_y_r);
  end

  // ---------------- stage B: memory addresses
  logic              s3_rnd_r;
  logic              s3_wen_r;
  logic [2:0]        s3_func_r;
  logic [15:0]       s3_addr_r;
  logic [15:0]       s3_data_r;
  logic [SCL_AW-1:0] s3_scl_addr_r;
  logic [LID_AW-1:0] s3_lid_addr_r;
  logic [POL_AW-1:0] s3_pol_addr_r;
  logic              s3_iris_r;
  logic [10:0]       s3_px_r;
  logic [10:0]       s3_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_rnd_r <= 1'b0;
      s3_wen_r <= 1'b0;
    end else begin
      s3_rnd_r <= s2_rnd_r;
      s3_wen_r <= s2_wen_r;
    end
  end

  always_ff @(posedge clk) begin
    s3_func_r     <= s2_func_r;
    s3_addr_r     <= s2_addr_r;
    s3_data_r     <= s2_data_r;
    s3_scl_addr_r <= SCL_AW'(32'(s2_cy_r) * SCLERA_SIZE + 32'(s2_cx_r));
    s3_lid_addr_r <= LID_AW'(32'(s2_sy_r) * SCREEN_SIZE + 32'(s2_lx_r));
    s3_pol_addr_r <= POL_AW'(32'(s2_iy_r) * IRIS_SIZE + 32'(s2_ix_r));
    s3_iris_r     <= s2_iris_r;
    s3_px_r       <= s2_px_r;
    s3_py_r       <= s2_py_r;
  end

  // ---------------- stage C: sclera, lid and polar memories
  logic [15:0] sclera_mem [SCL_DEPTH];
  logic [7:0]  upper_mem  [LID_DEPTH];
  logic [7:0]  lower_mem  [LID_DEPTH];
  logic [15:0] polar_mem  [POL_DEPTH];

  logic        wr_sclera;
  logic        wr_upper;
  logic        wr_lower;
  logic        wr_polar;
  logic        wr_iris;

  always_comb begin
    wr_sclera = s3_wen_r && (s3_func_r == FUNC_SCLERA) && (32'(s3_addr_r) < SCL_DEPTH);
    wr_upper  = s3_wen_r && (s3_func_r == FUNC_UPPER) && (32'(s3_addr_r) < LID_DEPTH);
    wr_lower  = s3_wen_r && (s3_func_r == FUNC_LOWER) && (32'(s3_addr_r) < LID_DEPTH);
    wr_polar  = s3_wen_r && (s3_func_r == FUNC_POLAR) && (32'(s3_addr_r) < POL_DEPTH);
    wr_iris   = s3_wen_r && (s3_func_r == FUNC_IRIS) && (32'(s3_addr_r) < IRIS_DEPTH);
  end

  logic [15:0] s4_sclera_r;
  logic [7:0]  s4_upper_r;
  logic [7:0]  s4_lower_r;
  logic [15:0] s4_polar_r;

  always_ff @(posedge clk) begin
    if (wr_sclera) sclera_mem[SCL_AW'(s3_addr_r)] <= s3_data_r;
    s4_sclera_r <= sclera_mem[s3_scl_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wr_upper) upper_mem[LID_AW'(s3_addr_r)] <= s3_data_r[7:0];
    s4_upper_r <= upper_mem[s3_lid_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wr_lower) lower_mem[LID_AW'(s3_addr_r)] <= s3_data_r[7:0];
    s4_lower_r <= lower_mem[s3_lid_addr_r];
  end

  always_ff @(posedge clk) begin
    if (wr_polar) polar_mem[POL_AW'(s3_addr_r)] <= s3_data_r;
    s4_polar_r <= polar_mem[s3_pol_addr_r];
  end

  logic               s4_rnd_r;
  logic               s4_iwen_r;
  logic [IRIS_AW-1:0] s4_iaddr_r;
  logic [15:0]        s4_idata_r;
  logic               s4_iris_r;
  logic [10:0]        s4_px_r;
  logic [10:0]        s4_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_rnd_r  <= 1'b0;
      s4_iwen_r <= 1'b0;
    end else begin
      s4_rnd_r  <= s3_rnd_r;
      s4_iwen_r <= wr_iris;
    end
  end

  always_ff @(posedge clk) begin
    s4_iaddr_r <= IRIS_AW'(s3_addr_r);
    s4_idata_r <= s3_data_r;
    s4_iris_r  <= s3_iris_r;
    s4_px_r    <= s3_px_r;
    s4_py_r    <= s3_py_r;
  end

  // ---------------- stage D: eyelid test, distance scaling, angle column
  logic               s5_rnd_r;
  logic               s5_iwen_r;
  logic [IRIS_AW-1:0] s5_iaddr_r;
  logic [15:0]        s5_idata_r;
  logic               s5_iris_r;
  logic               s5_cover_r;
  logic [18:0]        s5_prod_r;
  logic [COL_AW-1:0]  s5_acol_r;
  logic [15:0]        s5_sclera_r;
  logic [10:0]        s5_px_r;
  logic [10:0]        s5_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_rnd_r  <= 1'b0;
      s5_iwen_r <= 1'b0;
    end else begin
      s5_rnd_r  <= s4_rnd_r;
      s5_iwen_r <= s4_iwen_r;
    end
  end

  always_ff @(posedge clk) begin
    s5_iaddr_r  <= s4_iaddr_r;
    s5_idata_r  <= s4_idata_r;
    s5_iris_r   <= s4_iris_r;
    s5_cover_r  <= (s4_lower_r <= lower_thr_r) || (s4_upper_r <= upper_thr_r);
    s5_prod_r   <= 19'(iris_scale_r) * 19'(s4_polar_r[DIST_W-1:0]);
    s5_acol_r   <= COL_AW'((32'(s4_polar_r[15:DIST_W]) * IRIS_MAP_COLS) >> ANGLE_SHIFT);
    s5_sclera_r <= s4_sclera_r;
    s5_px_r     <= s4_px_r;
    s5_py_r     <= s4_py_r;
  end

  // ---------------- stage E: iris row range check
  logic [11:0] dist_row;

  assign dist_row = s5_prod_r[18:SCALE_SHIFT];

  logic               s6_rnd_r;
  logic               s6_iwen_r;
  logic [IRIS_AW-1:0] s6_iaddr_r;
  logic [15:0]        s6_idata_r;
  logic               s6_cover_r;
  logic               s6_use_iris_r;
  logic [ROW_AW-1:0]  s6_drow_r;
  logic [COL_AW-1:0]  s6_acol_r;
  logic [15:0]        s6_sclera_r;
  logic [10:0]        s6_px_r;
  logic [10:0]        s6_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_rnd_r  <= 1'b0;
      s6_iwen_r <= 1'b0;
    end else begin
      s6_rnd_r  <= s5_rnd_r;
      s6_iwen_r <= s5_iwen_r;
    end
  end

  always_ff @(posedge clk) begin
    s6_iaddr_r    <= s5_iaddr_r;
    s6_idata_r    <= s5_idata_r;
    s6_cover_r    <= s5_cover_r;
    s6_use_iris_r <= s5_iris_r && (dist_row < ROW_LIM);
    s6_drow_r     <= ROW_AW'(dist_row);
    s6_acol_r     <= s5_acol_r;
    s6_sclera_r   <= s5_sclera_r;
    s6_px_r       <= s5_px_r;
    s6_py_r       <= s5_py_r;
  end

  // ---------------- stage F: iris map address
  logic               s7_rnd_r;
  logic               s7_iwen_r;
  logic [IRIS_AW-1:0] s7_iaddr_r;
  logic [15:0]        s7_idata_r;
  logic               s7_cover_r;
  logic               s7_use_iris_r;
  logic [IRIS_AW-1:0] s7_raddr_r;
  logic [15:0]        s7_sclera_r;
  logic [10:0]        s7_px_r;
  logic [10:0]        s7_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_rnd_r  <= 1'b0;
      s7_iwen_r <= 1'b0;
    end else begin
      s7_rnd_r  <= s6_rnd_r;
      s7_iwen_r <= s6_iwen_r;
    end
  end

  always_ff @(posedge clk) begin
    s7_iaddr_r    <= s6_iaddr_r;
    s7_idata_r    <= s6_idata_r;
    s7_cover_r    <= s6_cover_r;
    s7_use_iris_r <= s6_use_iris_r;
    s7_raddr_r    <= IRIS_AW'(32'(s6_drow_r) * IRIS_MAP_COLS + 32'(s6_acol_r));
    s7_sclera_r   <= s6_sclera_r;
    s7_px_r       <= s6_px_r;
    s7_py_r       <= s6_py_r;
  end

  // ---------------- stage G: iris memory
  logic [15:0] iris_mem [IRIS_DEPTH];
  logic [15:0] s8_iris_r;

  always_ff @(posedge clk) begin
    if (s7_iwen_r) iris_mem[s7_iaddr_r] <= s7_idata_r;
    s8_iris_r <= iris_mem[s7_raddr_r];
  end

  logic        s8_rnd_r;
  logic        s8_cover_r;
  logic        s8_use_iris_r;
  logic [15:0] s8_sclera_r;
  logic [10:0] s8_px_r;
  logic [10:0] s8_py_r;

  always_ff @(posedge clk) begin
    if (!rst_n) s8_rnd_r <= 1'b0;
    else        s8_rnd_r <= s7_rnd_r;
  end

  always_ff @(posedge clk) begin
    s8_cover_r    <= s7_cover_r;
    s8_use_iris_r <= s7_use_iris_r;
    s8_sclera_r   <= s7_sclera_r;
    s8_px_r       <= s7_px_r;
    s8_py_r       <= s7_py_r;
  end

  // ---------------- stage H: color select and output register
  logic        out_valid_r;
  logic [10:0] out_px_r;
  logic [10:0] out_py_r;
  logic [15:0] out_color_r;
  logic [15:0] color_nxt;

  always_comb begin
    if (s8_cover_r) begin
      color_nxt = '0;
    end else if (s8_use_iris_r) begin
      color_nxt = s8_iris_r;
    end else begin
      color_nxt = s8_sclera_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else        out_valid_r <= s8_rnd_r;
  end

  always_ff @(posedge clk) begin
    out_px_r    <= s8_px_r;
    out_py_r    <= s8_py_r;
    out_color_r <= color_nxt;
  end

  assign out_valid   = out_valid_r;
  assign out_pixel_x = out_px_r;
  assign out_pixel_y = out_py_r;
  assign out_color   = out_color_r;

`ifndef SYNTH
  // a render transaction inside the screen yields a result after the pipeline
  a_render_result: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func == FUNC_RENDER
     && 32'(in_screen_x) < SCREEN_SIZE && 32'(in_screen_y) < SCREEN_SIZE)
    |-> ##9 out_valid)
    else $error("render transaction lost");

  // write transactions never yield a result
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_func != FUNC_RENDER) |-> ##9 !out_valid)
    else $error("result from a write transaction");

  // a covered pixel is black
  a_cover_black: assert property (@(posedge clk) disable iff (!rst_n)
    (s8_rnd_r && s8_cover_r) |=> (out_valid && out_color == 16'd0))
    else $error("eyelid pixel not black");
`endif

endmodule

`default_nettype wire

// ===== test/eye_pixel_renderer_top_tb.sv =====
// ----------------------------------------------------------------------------
// eye_pixel_renderer_top_tb
// drives render, table write and spare transactions into the eye pixel
// renderer and checks every displayed pixel against a local model of the
// five image memories and the configuration registers; image entries are
// loaded before any render that reads them, and settings change between
// phases while the block is idle
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

import eyepix_pkg::*;

typedef struct packed {
  logic [10:0] px;
  logic [10:0] py;
  logic [15:0] color;
} pixel_t;

class eye_pixel_scoreboard;
  logic [15:0] sclera [SCLERA_SIZE_DEF*SCLERA_SIZE_DEF];
  logic [7:0]  upper_lid [SCREEN_SIZE_DEF*SCREEN_SIZE_DEF];
  logic [7:0]  lower_lid [SCREEN_SIZE_DEF*SCREEN_SIZE_DEF];
  logic [15:0] polar [IRIS_SIZE_DEF*IRIS_SIZE_DEF];
  logic [15:0] iris [IRIS_MAP_ROWS_DEF*IRIS_MAP_COLS_DEF];
  bit sclera_set [SCLERA_SIZE_DEF*SCLERA_SIZE_DEF];
  bit upper_set [SCREEN_SIZE_DEF*SCREEN_SIZE_DEF];
  bit lower_set [SCREEN_SIZE_DEF*SCREEN_SIZE_DEF];
  bit polar_set [IRIS_SIZE_DEF*IRIS_SIZE_DEF];
  bit iris_set [IRIS_MAP_ROWS_DEF*IRIS_MAP_COLS_DEF];

  bit [11:0] iris_scale = IRIS_SCALE_RST;
  bit [7:0]  origin_x = 0;
  bit [7:0]  origin_y = 0;
  bit [7:0]  upper_thr = 0;
  bit [7:0]  lower_thr = 0;
  bit        mirror = 0;
  bit [9:0]  offset_x = 0;
  bit [9:0]  offset_y = 0;

  pixel_t pending_pixels [$];
  int mismatches = 0;

  function int lid_addr(int sx, int sy);
    return sy * SCREEN_SIZE_DEF + (mirror ? SCREEN_SIZE_DEF - 1 - sx : sx);
  endfunction

  function int sclera_addr(int sx, int sy);
    return ((int'(origin_y) + sy) % SCLERA_SIZE_DEF) * SCLERA_SIZE_DEF
           + (int'(origin_x) + sx) % SCLERA_SIZE_DEF;
  endfunction

  // unwrapped position against the iris square
  function bit polar_addr(int sx, int sy, output int idx);
    int border;
    int ix;
    int iy;
    border = (SCLERA_SIZE_DEF - IRIS_SIZE_DEF) / 2;
    ix = int'(origin_x) + sx - border;
    iy = int'(origin_y) + sy - border;
    idx = iy * IRIS_SIZE_DEF + ix;
    return ix >= 0 && iy >= 0 && ix < IRIS_SIZE_DEF && iy < IRIS_SIZE_DEF;
  endfunction

  function int iris_row(logic [15:0] p);
    return (int'(iris_scale) * int'(p[DIST_W-1:0])) >> SCALE_SHIFT;
  endfunction

  function int iris_addr(logic [15:0] p);
    return iris_row(p) * IRIS_MAP_COLS_DEF
           + ((IRIS_MAP_COLS_DEF * int'(p[15:DIST_W])) >> ANGLE_SHIFT);
  endfunction

  function logic [15:0] pixel_color(int sx, int sy);
    int lid;
    int pidx;
    lid = lid_addr(sx, sy);
    if (lower_lid[lid] <= lower_thr || upper_lid[lid] <= upper_thr) return 16'h0000;
    if (!polar_addr(sx, sy, pidx)) return sclera[sclera_addr(sx, sy)];
    if (iris_row(polar[pidx]) >= IRIS_MAP_ROWS_DEF) return sclera[sclera_addr(sx, sy)];
    return iris[iris_addr(polar[pidx])];
  endfunction

  function bit loaded(logic [2:0] func, int idx);
    case (func)
      FUNC_SCLERA: return sclera_set[idx];
      FUNC_UPPER:  return upper_set[idx];
      FUNC_LOWER:  return lower_set[idx];
      FUNC_POLAR:  return polar_set[idx];
      FUNC_IRIS:   return iris_set[idx];
      default:     return 1'b0;
    endcase
  endfunction

  function void set_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] val);
    case (idx)
      REG_IRIS_SCALE: iris_scale = val[11:0];
      REG_SCLERA_OX:  origin_x = val[7:0];
      REG_SCLERA_OY:  origin_y = val[7:0];
      REG_UPPER_THR:  upper_thr = val[7:0];
      REG_LOWER_THR:  lower_thr = val[7:0];
      REG_EYE_SELECT: mirror = val[0];
      REG_OFFSET_X:   offset_x = val[9:0];
      REG_OFFSET_Y:   offset_y = val[9:0];
      default: ;
    endcase
  endfunction

  function void note_item(logic [2:0] func, logic [15:0] addr, logic [15:0] data,
                          logic [6:0] sx, logic [6:0] sy);
    pixel_t pix;
    int a;
    a = int'(addr);
    case (func)
      FUNC_RENDER: begin
        if (sx < SCREEN_SIZE_DEF && sy < SCREEN_SIZE_DEF) begin
          pix.px = 11'(int'(sx) + int'(offset_x));
          pix.py = 11'(int'(sy) + int'(offset_y));
          pix.color = pixel_color(int'(sx), int'(sy));
          pending_pixels.push_back(pix);
        end
      end
      FUNC_SCLERA: begin
        if (a < SCLERA_SIZE_DEF * SCLERA_SIZE_DEF) begin
          sclera[a] = data;
          sclera_set[a] = 1'b1;
        end
      end
      FUNC_UPPER: begin
        if (a < SCREEN_SIZE_DEF * SCREEN_SIZE_DEF) begin
          upper_lid[a] = data[7:0];
          upper_set[a] = 1'b1;
        end
      end
      FUNC_LOWER: begin
        if (a < SCREEN_SIZE_DEF * SCREEN_SIZE_DEF) begin
          lower_lid[a] = data[7:0];
          lower_set[a] = 1'b1;
        end
      end
      FUNC_POLAR: begin
        if (a < IRIS_SIZE_DEF * IRIS_SIZE_DEF) begin
          polar[a] = data;
          polar_set[a] = 1'b1;
        end
      end
      FUNC_IRIS: begin
        if (a < IRIS_MAP_ROWS_DEF * IRIS_MAP_COLS_DEF) begin
          iris[a] = data;
          iris_set[a] = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function void check_pixel(logic [10:0] px, logic [10:0] py, logic [15:0] color);
    pixel_t want;
    if (pending_pixels.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected pixel x=%0d y=%0d color=%h", px, py, color);
      return;
    end
    want = pending_pixels.pop_front();
    if (want.px !== px || want.py !== py || want.color !== color) begin
      mismatches++;
      if (mismatches <= 10)
        $display("pixel mismatch: expected x=%0d y=%0d color=%h, got x=%0d y=%0d color=%h",
                 want.px, want.py, want.color, px, py, color);
    end
  endfunction
endclass

module eye_pixel_renderer_top_tb;

  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 12;
  localparam int ITEMS_PER_PHASE = 47;
  localparam logic [2:0] FUNC_SPARE_A = 3'd6;
  localparam logic [2:0] FUNC_SPARE_B = 3'd7;

  logic              clk;
  logic              rst_n;
  logic              start;
  logic              busy;
  logic [2:0]        in_func;
  logic [15:0]       in_address;
  logic [15:0]       in_data;
  logic [6:0]        in_screen_x;
  logic [6:0]        in_screen_y;
  logic              out_valid;
  logic [10:0]       out_pixel_x;
  logic [10:0]       out_pixel_y;
  logic [15:0]       out_color;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [CFG_IW-1:0] cfg_index;
  logic [CFG_DW-1:0] cfg_data;

  eye_pixel_scoreboard sb;
  int idle_cycles = 0;
  int items_sent = 0;
  int calm_left = 0;
  int last_x = 0;
  int last_y = 0;

  eye_pixel_renderer_top i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_func     (in_func),
    .in_address  (in_address),
    .in_data     (in_data),
    .in_screen_x (in_screen_x),
    .in_screen_y (in_screen_y),
    .out_valid   (out_valid),
    .out_pixel_x (out_pixel_x),
    .out_pixel_y (out_pixel_y),
    .out_color   (out_color),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (start && !busy)
        sb.note_item(in_func, in_address, in_data, in_screen_x, in_screen_y);
      if (out_valid)
        sb.check_pixel(out_pixel_x, out_pixel_y, out_color);
    end
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("eye_pixel_renderer_top_tb NOT OK");
    $finish;
  end

  function automatic int sender_gap();
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if ($urandom_range(0, 19) == 0) calm_left = $urandom_range(8, 30);
    return $urandom_range(0, 5);
  endfunction

  function automatic int pick(int hi);
    case ($urandom_range(0, 3))
      0: return 0;
      1: return hi;
      default: return $urandom_range(0, hi);
    endcase
  endfunction

  task automatic send_item(logic [2:0] func, logic [15:0] addr, logic [15:0] data,
                           logic [6:0] sx, logic [6:0] sy);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_func = func;
    in_address = addr;
    in_data = data;
    in_screen_x = sx;
    in_screen_y = sy;
    start = 1'b1;
    do @(posedge clk); while (busy);
    @(negedge clk);
    start = 1'b0;
    if (func != FUNC_SPARE_A && func != FUNC_SPARE_B) items_sent++;
  endtask

  // lid values mostly above threshold so that pixels stay open
  task automatic load_entry(logic [2:0] func, int idx);
    logic [15:0] value;
    int thr;
    value = 16'($urandom);
    thr = (func == FUNC_UPPER) ? int'(sb.upper_thr) : int'(sb.lower_thr);
    if ((func == FUNC_UPPER || func == FUNC_LOWER) && thr < 255 && $urandom_range(0, 5) != 0)
      value[7:0] = 8'($urandom_range(thr + 1, 255));
    if (!sb.loaded(func, idx) || $urandom_range(0, 7) == 0)
      send_item(func, 16'(idx), value, 7'($urandom), 7'($urandom));
  endtask

  task automatic render_at(int sx, int sy);
    int pidx;
    load_entry(FUNC_LOWER, sb.lid_addr(sx, sy));
    load_entry(FUNC_UPPER, sb.lid_addr(sx, sy));
    load_entry(FUNC_SCLERA, sb.sclera_addr(sx, sy));
    if (sb.polar_addr(sx, sy, pidx)) begin
      load_entry(FUNC_POLAR, pidx);
      if (sb.iris_row(sb.polar[pidx]) < IRIS_MAP_ROWS_DEF)
        load_entry(FUNC_IRIS, sb.iris_addr(sb.polar[pidx]));
    end
    send_item(FUNC_RENDER, 16'($urandom), 16'($urandom), 7'(sx), 7'(sy));
    last_x = sx;
    last_y = sy;
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, int val);
    start = 1'b0;
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = CFG_DW'(val);
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid = 1'b0;
    sb.set_reg(idx, CFG_DW'(val));
  endtask

  task automatic settle();
    start = 1'b0;
    while (sb.pending_pixels.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic apply_config(int scale, int ox, int oy, int uthr, int lthr, int eye,
                              int offx, int offy);
    settle();
    write_reg(REG_IRIS_SCALE, scale);
    write_reg(REG_SCLERA_OX, ox);
    write_reg(REG_SCLERA_OY, oy);
    write_reg(REG_UPPER_THR, uthr);
    write_reg(REG_LOWER_THR, lthr);
    write_reg(REG_EYE_SELECT, eye);
    write_reg(REG_OFFSET_X, offx);
    write_reg(REG_OFFSET_Y, offy);
  endtask

  task automatic directed_items();
    int lid;
    render_at(0, 0);
    render_at(127, 127);
    render_at(64, 64);
    render_at(0, 127);
    render_at(127, 0);
    render_at(10, 10);
    // lid values right at the thresholds, just above the lower one and at the top for the upper one
    lid = sb.lid_addr(10, 10);
    send_item(FUNC_LOWER, 16'(lid), 16'hFF00, 7'd0, 7'd0);
    send_item(FUNC_RENDER, 16'hFFFF, 16'hFFFF, 7'd10, 7'd10);
    send_item(FUNC_LOWER, 16'(lid), 16'h0001, 7'd0, 7'd0);
    send_item(FUNC_UPPER, 16'(lid), 16'h0000, 7'd127, 7'd127);
    send_item(FUNC_RENDER, 16'h0000, 16'h0000, 7'd10, 7'd10);
    send_item(FUNC_UPPER, 16'(lid), 16'hFFFF, 7'd127, 7'd127);
    send_item(FUNC_RENDER, 16'hFFFF, 16'h0000, 7'd10, 7'd10);
    // writes past the end of the lid, polar and iris tables must not alias
    send_item(FUNC_LOWER, 16'h4000, 16'h0000, 7'd127, 7'd127);
    send_item(FUNC_UPPER, 16'hFFFF, 16'h0000, 7'd127, 7'd127);
    send_item(FUNC_POLAR, 16'h4000, 16'hFFFF, 7'd0, 7'd0);
    send_item(FUNC_IRIS, 16'hFFFF, 16'h0000, 7'd0, 7'd0);
    send_item(FUNC_SPARE_A, 16'h0000, 16'hFFFF, 7'd127, 7'd127);
    send_item(FUNC_SPARE_B, 16'hFFFF, 16'h0000, 7'd0, 7'd0);
    send_item(FUNC_SCLERA, 16'hFFFF, 16'hFFFF, 7'd127, 7'd0);
    send_item(FUNC_RENDER, 16'h0000, 16'hFFFF, 7'd0, 7'd0);
    send_item(FUNC_RENDER, 16'h0000, 16'hFFFF, 7'd127, 7'd127);
    send_item(FUNC_RENDER, 16'h0000, 16'hFFFF, 7'd64, 7'd64);
  endtask

  task automatic random_phase(int count);
    int goal;
    bit paused;
    goal = items_sent + count;
    paused = 1'b0;
    while (items_sent < goal) begin
      if (!paused && items_sent >= goal - count / 2) begin
        settle();
        paused = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: render_at($urandom_range(0, 127), $urandom_range(0, 127));
        5, 6: render_at(last_x, last_y);
        7: send_item(3'($urandom_range(FUNC_SCLERA, FUNC_IRIS)), 16'($urandom),
                     16'($urandom), 7'($urandom), 7'($urandom));
        8: send_item(3'($urandom_range(FUNC_SCLERA, FUNC_IRIS)),
                     16'($urandom_range(0, 16383)), 16'($urandom), 7'($urandom),
                     7'($urandom));
        default: send_item($urandom_range(0, 1) ? FUNC_SPARE_A : FUNC_SPARE_B,
                           16'($urandom), 16'($urandom), 7'($urandom), 7'($urandom));
      endcase
    end
  endtask

  initial begin
    sb = new;
    rst_n = 1'b0;
    start = 1'b0;
    in_func = FUNC_RENDER;
    in_address = '0;
    in_data = '0;
    in_screen_x = '0;
    in_screen_y = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_IRIS_SCALE;
    cfg_data = '0;
    repeat (8) @(negedge clk);
    rst_n = 1'b1;

    directed_items();
    random_phase(ITEMS_PER_PHASE);
    apply_config(128, 64, 64, 0, 0, 1, 1023, 1023);
    random_phase(ITEMS_PER_PHASE);
    apply_config(0, 255, 255, 40, 255, 0, 512, 3);
    random_phase(ITEMS_PER_PHASE);
    apply_config(4095, 0, 200, 255, 0, 1, 0, 1023);
    random_phase(ITEMS_PER_PHASE);
    apply_config(64, 96, 32, 20, 20, 0, 1023, 0);
    random_phase(ITEMS_PER_PHASE);
    repeat (3) begin
      apply_config(pick(4095), pick(255), pick(255), $urandom_range(0, 40),
                   $urandom_range(0, 40), $urandom_range(0, 1), pick(1023), pick(1023));
      random_phase(ITEMS_PER_PHASE);
    end
    settle();

    if (sb.mismatches == 0 && sb.pending_pixels.size() == 0)
      $display("eye_pixel_renderer_top_tb OK");
    else
      $display("eye_pixel_renderer_top_tb NOT OK");
    $finish;
  end

endmodule

// ===== files.f =====
design/eyepix_pkg.sv
design/eye_pixel_renderer_top.sv
test/eye_pixel_renderer_top_tb.sv
